### src/hcdg_pkg.sv
// hcdg_pkg: shared constants and types of the hammersley cap direction generator
// no dependencies; used by the term cell and the top level
`timescale 1ns / 1ps

package hcdg_pkg;

	// fixed point scale of all internal angles and cosines
	localparam int unsigned QB = 30;
	localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
	localparam logic [28:0] SIN15_Q30  = 29'd277904834;
	localparam logic [30:0] PIHALF_Q30 = 31'd1686629713;

	// quotient digits, root steps and term cells
	localparam int unsigned DIV_STEPS  = 30;
	localparam int unsigned SQRT_STEPS = 31;
	localparam int unsigned TERM_CELLS = 8;

	// phi series state handed from cell to cell
	typedef struct packed {
		logic [31:0]        ts;
		logic [31:0]        tc;
		logic signed [35:0] sn;
		logic signed [35:0] cs;
		logic [31:0]        x2;
		logic [1:0]         quad;
	} term_t;

	// per stage control
	typedef struct packed {
		logic vld;
		logic err;
	} ctl_t;

endpackage

### src/hcdg_div_cell.sv
// hcdg_div_cell: one restoring division step, one quotient bit per cell
// depends on nothing but its ports
`timescale 1ns / 1ps

module hcdg_div_cell #(
	parameter int CNT_W = 17
) (
	input  logic             clk,
	input  logic             en,
	input  logic [CNT_W-1:0] cnt,
	input  logic [CNT_W-1:0] rem_i,
	input  logic [29:0]      quo_i,
	output logic [CNT_W-1:0] rem_o,
	output logic [29:0]      quo_o
);
	logic [CNT_W:0]   r2;
	logic             ge;
	logic [CNT_W:0]   diff;
	logic [CNT_W-1:0] rem_s1;
	logic [29:0]      quo_s1;

	assign r2   = {rem_i, 1'b0};
	assign ge   = r2 >= {1'b0, cnt};
	assign diff = r2 - {1'b0, cnt};

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= ge ? diff[CNT_W-1:0] : r2[CNT_W-1:0];
			quo_s1 <= {quo_i[28:0], ge};
		end
	end

	assign rem_o = rem_s1;
	assign quo_o = quo_s1;
endmodule

### src/hcdg_sqrt_cell.sv
// hcdg_sqrt_cell: one step of the digit-by-digit integer square root
// carries the cosine along so it stays aligned with the root
`timescale 1ns / 1ps

module hcdg_sqrt_cell #(
	parameter int K = 30
) (
	input  logic        clk,
	input  logic        en,
	input  logic [60:0] rad_i,
	input  logic [61:0] root_i,
	input  logic [30:0] c30_i,
	output logic [60:0] rad_o,
	output logic [61:0] root_o,
	output logic [30:0] c30_o
);
	localparam logic [61:0] BIT = 62'd1 << (2 * K);

	logic [61:0] trial;
	logic [61:0] left;
	logic        take;
	logic [60:0] rad_s1;
	logic [61:0] root_s1;
	logic [30:0] c30_s1;

	assign trial = root_i + BIT;
	assign take  = {1'b0, rad_i} >= trial;
	assign left  = {1'b0, rad_i} - trial;

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s1  <= take ? left[60:0] : rad_i;
			root_s1 <= take ? ((root_i >> 1) + BIT) : (root_i >> 1);
			c30_s1  <= c30_i;
		end
	end

	assign rad_o  = rad_s1;
	assign root_o = root_s1;
	assign c30_o  = c30_s1;
endmodule

### src/hcdg_term_cell.sv
// hcdg_term_cell: one taylor term of sin and cos, two stages
// depends on hcdg_pkg (term_t)
`timescale 1ns / 1ps

module hcdg_term_cell #(
	parameter int N = 0
) (
	input  logic                clk,
	input  logic                en,
	input  hcdg_pkg::term_t     t_i,
	output hcdg_pkg::term_t     t_o
);
	import hcdg_pkg::*;

	localparam int KS = (2 * N + 2) * (2 * N + 3);
	localparam int KC = (2 * N + 1) * (2 * N + 2);
	localparam int SS = 32 + $clog2(KS);
	localparam int SC = 32 + $clog2(KC);
	localparam longint unsigned MS_L = ((64'd1 << SS) + KS - 1) / KS;
	localparam longint unsigned MC_L = ((64'd1 << SC) + KC - 1) / KC;
	localparam logic [32:0] MS = MS_L[32:0];
	localparam logic [32:0] MC = MC_L[32:0];

	logic signed [35:0] sn_s1, cs_s1, sn_s2, cs_s2;
	logic [63:0]        ps_s1, pc_s1;
	logic [64:0]        qs_s2, qc_s2, qs_sh, qc_sh;
	logic [31:0]        x2_s1, x2_s2;
	logic [1:0]         quad_s1, quad_s2;
	logic signed [35:0] ts_ext, tc_ext;

	assign ts_ext = $signed({4'd0, t_i.ts});
	assign tc_ext = $signed({4'd0, t_i.tc});

	// odd terms subtract
	always_ff @(posedge clk) begin
		if (en) begin
			sn_s1   <= (N % 2 == 1) ? t_i.sn - ts_ext : t_i.sn + ts_ext;
			cs_s1   <= (N % 2 == 1) ? t_i.cs - tc_ext : t_i.cs + tc_ext;
			ps_s1   <= 64'(t_i.ts) * 64'(t_i.x2);
			pc_s1   <= 64'(t_i.tc) * 64'(t_i.x2);
			x2_s1   <= t_i.x2;
			quad_s1 <= t_i.quad;
		end
	end

	// divide by the term constant through a rounded-up reciprocal
	always_ff @(posedge clk) begin
		if (en) begin
			qs_s2   <= 65'(ps_s1[61:30]) * 65'(MS);
			qc_s2   <= 65'(pc_s1[61:30]) * 65'(MC);
			sn_s2   <= sn_s1;
			cs_s2   <= cs_s1;
			x2_s2   <= x2_s1;
			quad_s2 <= quad_s1;
		end
	end

	assign qs_sh = qs_s2 >> SS;
	assign qc_sh = qc_s2 >> SC;

	always_comb begin
		t_o.ts   = qs_sh[31:0];
		t_o.tc   = qc_sh[31:0];
		t_o.sn   = sn_s2;
		t_o.cs   = cs_s2;
		t_o.x2   = x2_s2;
		t_o.quad = quad_s2;
	end
endmodule

### src/hammersley_cap_direction_generator_unit.sv
// hammersley_cap_direction_generator_unit: top level, apb register and cell chains
// depends on hcdg_pkg, hcdg_div_cell, hcdg_sqrt_cell, hcdg_term_cell
`timescale 1ns / 1ps

// channel   | dir | transaction carries
// s_*       | in  | tdata: sample_index
// m_*       | out | tdata: dir_x, dir_y, dir_z; tuser: index_error
// apb       | in  | point_count at register 0
//
// fully pipelined: one index per cycle while the result side does not stall
// the result path runs through the 30-cell divider chain and the 31-cell square root chain
// the sin/cos series runs beside the divider and waits in a delay line
// reset clears the valid line and sets point_count to 1; no clearing pass
// a stalled result holds the whole chain; s_tready is low only then

module hammersley_cap_direction_generator_unit #(
	parameter int INDEX_BITS = 16,
	parameter int FRAC_BITS  = 14,
	parameter int PDATA_W    = (INDEX_BITS + 1 > 32) ? 64 : 32,
	parameter int PADDR_W    = (INDEX_BITS + 1 > 32) ? 4 : 3
) (
	input  logic clk,
	input  logic arst_n,
	// [INDEX_BITS-1:0] sample_index
	input  logic                                          s_tvalid,
	output logic                                          s_tready,
	input  logic [((INDEX_BITS + 7) / 8) * 8 - 1:0]       s_tdata,
	// dir_x, dir_y, dir_z from the lowest bit up
	output logic                                          m_tvalid,
	input  logic                                          m_tready,
	output logic [((3 * FRAC_BITS + 12) / 8) * 8 - 1:0]   m_tdata,
	// index_error
	output logic                                          m_tuser,
	input  logic                                          psel,
	input  logic                                          penable,
	input  logic                                          pwrite,
	input  logic [PADDR_W-1:0]                            paddr,
	input  logic [PDATA_W-1:0]                            pwdata,
	output logic [PDATA_W-1:0]                            prdata,
	output logic                                          pready
);
	import hcdg_pkg::*;

	localparam int CNT_W   = INDEX_BITS + 1;
	localparam int ALIGN   = PADDR_W - 1;
	localparam int XW      = FRAC_BITS + 2;
	localparam int ZW      = FRAC_BITS + 1;
	localparam int TD_W    = ((3 * FRAC_BITS + 12) / 8) * 8;
	localparam int ZSH     = QB - FRAC_BITS;
	// stage numbers, stage 1 is the input register
	localparam int SQ_STG  = 1 + DIV_STEPS + 2 + SQRT_STEPS;
	localparam int PHI_STG = 1 + 2 + 2 * TERM_CELLS + 1;
	localparam int DLY     = SQ_STG - PHI_STG;
	localparam int NST     = SQ_STG + 2;

	// ---------------- configuration register ----------------
	logic [CNT_W-1:0] point_count_q;
	logic             wr_hit;

	assign pready = 1'b1;
	assign wr_hit = psel && penable && pwrite && pready && (paddr[ALIGN] == 1'b0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= CNT_W'(1);
		end else if (wr_hit) begin
			point_count_q <= pwdata[CNT_W-1:0];
		end
	end

	assign prdata = (paddr[ALIGN] == 1'b0) ? PDATA_W'(point_count_q) : '0;

	// ---------------- handshake and valid line ----------------
	logic en;
	ctl_t ctl_q [NST];
	logic [INDEX_BITS-1:0] idx_in;
	logic                  err_in;

	assign en       = !ctl_q[NST-1].vld || m_tready;
	assign s_tready = en;
	assign idx_in   = s_tdata[INDEX_BITS-1:0];
	assign err_in   = {1'b0, idx_in} >= point_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NST; i++) begin
				ctl_q[i] <= '0;
			end
		end else if (en) begin
			ctl_q[0].vld <= s_tvalid;
			ctl_q[0].err <= err_in;
			for (int i = 1; i < NST; i++) begin
				ctl_q[i] <= ctl_q[i-1];
			end
		end
	end

	// ---------------- stage 1: index and radical inverse ----------------
	logic [INDEX_BITS-1:0] idx_s1;
	logic [31:0]           idx32;
	logic [31:0]           phase;

	assign idx32 = 32'(idx_in);
	always_comb begin
		for (int b = 0; b < 32; b++) begin
			phase[31-b] = idx32[b];
		end
	end

	logic [31:0] phase_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1   <= idx_in;
			phase_s1 <= phase;
		end
	end

	// ---------------- divider chain: u = i * 2^30 / N ----------------
	logic [CNT_W-1:0] rem_c [DIV_STEPS+1];
	logic [29:0]      quo_c [DIV_STEPS+1];

	assign rem_c[0] = CNT_W'(idx_s1);
	assign quo_c[0] = '0;

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		hcdg_div_cell #(.CNT_W(CNT_W)) u_div (
			.clk   (clk),
			.en    (en),
			.cnt   (point_count_q),
			.rem_i (rem_c[j]),
			.quo_i (quo_c[j]),
			.rem_o (rem_c[j+1]),
			.quo_o (quo_c[j+1])
		);
	end

	// cos theta = 1 - u * sin15, then the radicand 1 - cos^2
	logic [58:0] wprod;
	logic [30:0] c30_s32, c30_s33;
	logic [61:0] csq;
	logic [60:0] rad_s33;

	assign wprod = 59'(quo_c[DIV_STEPS]) * 59'(SIN15_Q30);
	assign csq   = 62'(c30_s32) * 62'(c30_s32);

	always_ff @(posedge clk) begin
		if (en) begin
			c30_s32 <= ONE_Q30 - 31'(wprod[58:30]);
			rad_s33 <= 61'((62'd1 << 60) - csq);
			c30_s33 <= c30_s32;
		end
	end

	// ---------------- square root chain: sin theta ----------------
	logic [60:0] rad_c  [SQRT_STEPS+1];
	logic [61:0] root_c [SQRT_STEPS+1];
	logic [30:0] c30_c  [SQRT_STEPS+1];

	assign rad_c[0]  = rad_s33;
	assign root_c[0] = '0;
	assign c30_c[0]  = c30_s33;

	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
		hcdg_sqrt_cell #(.K(SQRT_STEPS - 1 - j)) u_sqrt (
			.clk    (clk),
			.en     (en),
			.rad_i  (rad_c[j]),
			.root_i (root_c[j]),
			.c30_i  (c30_c[j]),
			.rad_o  (rad_c[j+1]),
			.root_o (root_c[j+1]),
			.c30_o  (c30_c[j+1])
		);
	end

	// ---------------- phi series: runs alongside the divider ----------------
	logic [60:0] xprod;
	logic [31:0] x_s2, x2_s3, x_s3;
	logic [1:0]  quad_s2, quad_s3;
	logic [61:0] x2prod;

	assign xprod  = 61'(phase_s1[29:0]) * 61'(PIHALF_Q30);
	assign x2prod = 62'(x_s2) * 62'(x_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2    <= {1'b0, xprod[60:30]};
			quad_s2 <= phase_s1[31:30];
			x_s3    <= x_s2;
			x2_s3   <= x2prod[61:30];
			quad_s3 <= quad_s2;
		end
	end

	term_t term_c [TERM_CELLS+1];

	always_comb begin
		term_c[0].ts   = x_s3;
		term_c[0].tc   = 32'(ONE_Q30);
		term_c[0].sn   = '0;
		term_c[0].cs   = '0;
		term_c[0].x2   = x2_s3;
		term_c[0].quad = quad_s3;
	end

	for (genvar n = 0; n < TERM_CELLS; n++) begin : g_term
		hcdg_term_cell #(.N(n)) u_term (
			.clk (clk),
			.en  (en),
			.t_i (term_c[n]),
			.t_o (term_c[n+1])
		);
	end

	// last term, clamp to [0, 1], quadrant fold
	logic signed [35:0] sn_end, cs_end;
	logic [30:0]        s_cl, c_cl;
	logic signed [31:0] cphi, sphi, cphi_s20, sphi_s20;

	assign sn_end = term_c[TERM_CELLS].sn + $signed({4'd0, term_c[TERM_CELLS].ts});
	assign cs_end = term_c[TERM_CELLS].cs + $signed({4'd0, term_c[TERM_CELLS].tc});

	always_comb begin
		if (sn_end < 0) begin
			s_cl = '0;
		end else if (sn_end > $signed(36'(ONE_Q30))) begin
			s_cl = ONE_Q30;
		end else begin
			s_cl = sn_end[30:0];
		end
		if (cs_end < 0) begin
			c_cl = '0;
		end else if (cs_end > $signed(36'(ONE_Q30))) begin
			c_cl = ONE_Q30;
		end else begin
			c_cl = cs_end[30:0];
		end
		case (term_c[TERM_CELLS].quad)
			2'd0: begin
				cphi = $signed({1'b0, c_cl});
				sphi = $signed({1'b0, s_cl});
			end
			2'd1: begin
				cphi = -$signed({1'b0, s_cl});
				sphi = $signed({1'b0, c_cl});
			end
			2'd2: begin
				cphi = -$signed({1'b0, c_cl});
				sphi = -$signed({1'b0, s_cl});
			end
			default: begin
				cphi = $signed({1'b0, s_cl});
				sphi = -$signed({1'b0, c_cl});
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cphi_s20 <= cphi;
			sphi_s20 <= sphi;
		end
	end

	// delay line until sin theta is ready
	logic signed [31:0] cphi_dly_q [DLY];
	logic signed [31:0] sphi_dly_q [DLY];

	always_ff @(posedge clk) begin
		if (en) begin
			cphi_dly_q[0] <= cphi_s20;
			sphi_dly_q[0] <= sphi_s20;
			for (int i = 1; i < DLY; i++) begin
				cphi_dly_q[i] <= cphi_dly_q[i-1];
				sphi_dly_q[i] <= sphi_dly_q[i-1];
			end
		end
	end

	// ---------------- scale by sin theta ----------------
	logic signed [31:0] ca, sa;
	logic [30:0]        cmag, smag, s30;
	logic [61:0]        px_s65, py_s65;
	logic               nx_s65, ny_s65;
	logic [ZW-1:0]      z_s65;
	logic [30:0]        c30_end;
	logic [30:0]        z_full;

	assign ca      = cphi_dly_q[DLY-1];
	assign sa      = sphi_dly_q[DLY-1];
	assign cmag    = ca[31] ? 31'(-ca) : ca[30:0];
	assign smag    = sa[31] ? 31'(-sa) : sa[30:0];
	assign s30     = root_c[SQRT_STEPS][30:0];
	assign c30_end = c30_c[SQRT_STEPS];

	if (ZSH == 0) begin : g_z_exact
		assign z_full = c30_end;
	end else begin : g_z_round
		assign z_full = (c30_end + (31'd1 << (ZSH - 1))) >> ZSH;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s65 <= 62'(cmag) * 62'(s30);
			py_s65 <= 62'(smag) * 62'(s30);
			nx_s65 <= ca[31];
			ny_s65 <= sa[31];
			z_s65  <= z_full[ZW-1:0];
		end
	end

	// round half up, clamp to one, restore sign
	logic [62:0]   rx, ry;
	logic [XW-1:0] mx, my, ox, oy;
	localparam logic [62:0] HALF = 63'd1 << (59 - FRAC_BITS);
	localparam logic [XW-1:0] FULL = XW'(1) << FRAC_BITS;

	assign rx = (63'(px_s65) + HALF) >> (60 - FRAC_BITS);
	assign ry = (63'(py_s65) + HALF) >> (60 - FRAC_BITS);
	assign mx = (rx > 63'(FULL)) ? FULL : rx[XW-1:0];
	assign my = (ry > 63'(FULL)) ? FULL : ry[XW-1:0];
	assign ox = nx_s65 ? XW'(-mx) : mx;
	assign oy = ny_s65 ? XW'(-my) : my;

	// ---------------- output register ----------------
	logic [XW-1:0] dir_x_q, dir_y_q;
	logic [ZW-1:0] dir_z_q;
	logic          index_error_q;

	always_ff @(posedge clk) begin
		if (en) begin
			index_error_q <= ctl_q[NST-2].err;
			dir_x_q       <= ctl_q[NST-2].err ? '0 : ox;
			dir_y_q       <= ctl_q[NST-2].err ? '0 : oy;
			dir_z_q       <= ctl_q[NST-2].err ? '0 : z_s65;
		end
	end

	assign m_tvalid = ctl_q[NST-1].vld;
	assign m_tdata  = TD_W'({dir_z_q, dir_y_q, dir_x_q});
	assign m_tuser  = index_error_q;
endmodule

### verif/hcdg_dir_checker.sv
// hcdg_dir_checker: watches the apb, input and result channels of the cap direction generator
// predicts each direction from the tracked point_count and compares it with the result stream
`timescale 1ns / 1ps

module hcdg_dir_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,
	input  logic        m_tuser,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output int          fail_count,
	output int          pending_count,
	output int          result_count
);

	localparam logic [2:0] POINT_COUNT_ADDR = 3'd0;
	localparam longint unsigned Q30_ONE = 64'd1 << 30;
	localparam longint unsigned SIN15_Q30_C = 64'd277904834;
	localparam longint unsigned PIHALF_Q30_C = 64'd1686629713;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [14:0]        z;
		logic               err;
	} dir_t;

	logic [16:0] point_count_q;
	dir_t        dir_expected[$];

	function automatic longint unsigned root_floor(input longint unsigned n);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint clamp_q30(input longint v);
		if (v < 0)
			return 0;
		if (v > longint'(Q30_ONE))
			return longint'(Q30_ONE);
		return v;
	endfunction

	// round half up to q1.14 and apply the sign of the angle term
	function automatic logic [15:0] scale_q14(input longint a30, input longint unsigned s30);
		longint unsigned mag;
		longint unsigned m;
		mag = (a30 < 0) ? longint'(-a30) : a30;
		m = (mag * s30 + (64'd1 << 45)) >> 46;
		if (m > 64'd16384)
			m = 64'd16384;
		if (a30 < 0)
			m = 64'd0 - m;
		return m[15:0];
	endfunction

	function automatic dir_t cap_direction(input logic [15:0] idx, input logic [16:0] cnt);
		dir_t            d;
		longint unsigned u30, w30, c30, s30, r, x, x2, ts, tc;
		longint          sn, cs, c, s, cphi, sphi;
		logic [31:0]     phase;
		d = '0;
		if ({1'b0, idx} >= cnt) begin
			d.err = 1'b1;
			return d;
		end
		u30 = (longint'(idx) << 30) / longint'(cnt);
		w30 = (u30 * SIN15_Q30_C) >> 30;
		c30 = Q30_ONE - w30;
		s30 = root_floor((64'd1 << 60) - c30 * c30);
		// radical inverse: reversed index as a fraction of one turn
		for (int k = 0; k < 32; k++)
			phase[31 - k] = (k < 16) ? idx[k] : 1'b0;
		r = phase[29:0];
		x = (r * PIHALF_Q30_C) >> 30;
		x2 = (x * x) >> 30;
		ts = x;
		tc = Q30_ONE;
		sn = 0;
		cs = 0;
		for (int n = 0; n < 9; n++) begin
			if (n % 2 == 1) begin
				sn = sn - longint'(ts);
				cs = cs - longint'(tc);
			end else begin
				sn = sn + longint'(ts);
				cs = cs + longint'(tc);
			end
			ts = ((ts * x2) >> 30) / longint'((2 * n + 2) * (2 * n + 3));
			tc = ((tc * x2) >> 30) / longint'((2 * n + 1) * (2 * n + 2));
		end
		c = clamp_q30(cs);
		s = clamp_q30(sn);
		case (phase[31:30])
			2'd0: begin cphi = c;  sphi = s;  end
			2'd1: begin cphi = -s; sphi = c;  end
			2'd2: begin cphi = -c; sphi = -s; end
			default: begin cphi = s; sphi = -c; end
		endcase
		d.x = scale_q14(cphi, s30);
		d.y = scale_q14(sphi, s30);
		d.z = 15'((c30 + (64'd1 << 15)) >> 16);
		return d;
	endfunction

	assign pending_count = dir_expected.size();

	always_ff @(posedge clk or negedge arst_n) begin
		dir_t e;
		dir_t a;
		if (!arst_n) begin
			point_count_q <= 17'd1;
			fail_count    <= 0;
			result_count  <= 0;
			dir_expected.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr == POINT_COUNT_ADDR)
				point_count_q <= pwdata[16:0];
			if (s_tvalid && s_tready)
				dir_expected.insert(dir_expected.size(),
					cap_direction(s_tdata, point_count_q));
			if (m_tvalid && m_tready) begin
				result_count <= result_count + 1;
				a.x   = m_tdata[15:0];
				a.y   = m_tdata[31:16];
				a.z   = m_tdata[46:32];
				a.err = m_tuser;
				if (dir_expected.size() == 0) begin
					if (fail_count < 10)
						$display("checker: unexpected result x=%0d y=%0d z=%0d err=%0b",
							a.x, a.y, a.z, a.err);
					fail_count <= fail_count + 1;
				end else begin
					e = dir_expected.pop_front();
					if (e !== a) begin
						if (fail_count < 10)
							$display("checker: exp x=%0d y=%0d z=%0d e=%0b got %0d %0d %0d %0b",
								e.x, e.y, e.z, e.err, a.x, a.y, a.z, a.err);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

### verif/tb_hammersley_cap_direction_generator_unit.sv
// tb_hammersley_cap_direction_generator_unit: stimulus and verdict for the direction generator
// depends on hammersley_cap_direction_generator_unit and hcdg_dir_checker
`timescale 1ns / 1ps

module tb_hammersley_cap_direction_generator_unit;

	localparam logic [2:0] POINT_COUNT_ADDR = 3'd0;
	// idling modes of the two channels
	localparam int MODE_NONE = 0;
	localparam int MODE_SEND = 1;
	localparam int MODE_RECV = 2;
	localparam int MODE_BOTH = 3;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // sample_index
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;   // dir_x [15:0], dir_y [31:16], dir_z [46:32], zero pad
	logic        m_tuser;   // index_error
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int fail_count, pending_count, result_count;
	int idle_mode;
	int hold_request;      // asks the receiver for one long hold-off
	int sent_count;
	logic [16:0] cur_count;

	hammersley_cap_direction_generator_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	hcdg_dir_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.fail_count(fail_count), .pending_count(pending_count), .result_count(result_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard stop in case the pipeline never drains
	initial begin
		#2000000;
		$display("tb_hammersley_cap_direction_generator_unit: done, errors");
		$finish;
	end

	// result side: random stalls by mode, plus one long hold-off counted here
	initial begin
		int hold_left;
		hold_left = 0;
		m_tready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				hold_request = 0;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (idle_mode == MODE_RECV)
				m_tready <= ($urandom_range(0, 99) >= 58);
			else if (idle_mode == MODE_BOTH)
				m_tready <= ($urandom_range(0, 99) >= 9);
			else
				m_tready <= 1'b1;
		end
	end

	function automatic bit sender_idles();
		if (idle_mode == MODE_SEND)
			return $urandom_range(0, 99) < 58;
		if (idle_mode == MODE_BOTH)
			return $urandom_range(0, 99) < 9;
		return 1'b0;
	endfunction

	// one input transaction; called right after a rising edge or at start
	task automatic send_index(input logic [15:0] idx);
		bit ok;
		@(negedge clk);
		while (sender_idles()) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= idx;
		forever begin
			#1 ok = s_tready;
			@(posedge clk);
			if (ok)
				break;
			@(negedge clk);
		end
		sent_count++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_count != 0)
			@(negedge clk);
	endtask

	// waits for the pipeline to drain, plus an extra wait, before the write
	task automatic write_point_count(input logic [16:0] value);
		wait_drained();
		repeat (80) @(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= POINT_COUNT_ADDR;
		pwdata  <= {15'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cur_count = value;
	endtask

	// mostly indices inside the sequence, the rest anywhere
	function automatic logic [15:0] pick_index();
		if (cur_count != 0 && $urandom_range(0, 99) < 85)
			return 16'($urandom_range(0, int'(cur_count) - 1));
		return 16'($urandom_range(0, 65535));
	endfunction

	initial begin
		logic [16:0] counts[8];
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		idle_mode    = MODE_NONE;
		hold_request = 0;
		sent_count   = 0;
		cur_count    = 17'd1;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset count, then the full count with quadrant edges
		send_index(16'd0);
		send_index(16'd1);
		send_index(16'hFFFF);
		write_point_count(17'h10000);
		send_index(16'd0);
		send_index(16'd1);
		send_index(16'hFFFF);
		send_index(16'h8000);
		send_index(16'h4000);
		send_index(16'hC000);
		send_index(16'h2000);
		send_index(16'hAAAA);
		send_index(16'h5555);
		// zero count flags every index
		write_point_count(17'd0);
		send_index(16'd0);
		send_index(16'hFFFF);
		// boundary around a mid count
		write_point_count(17'd1000);
		send_index(16'd999);
		send_index(16'd1000);
		send_index(16'd500);
		send_index(16'd0);

		counts = '{17'h10000, 17'd37, 17'd1, 17'd4096,
			17'($urandom_range(2, 65536)), 17'd65535, 17'd300, 17'h10000};
		for (int p = 0; p < 8; p++) begin
			write_point_count(counts[p]);
			idle_mode = p % 4;
			for (int k = 0; k < 130; k++) begin
				// fill the pipeline against a long result stall
				if (p == 3 && k == 10)
					hold_request = 1;
				// sender pause until every result is back
				if (p == 5 && k == 60)
					wait_drained();
				send_index(pick_index());
			end
		end

		wait_drained();
		repeat (100) @(posedge clk);
		$display("covered %0d index transactions, %0d results, counts 0..65536, four idling modes",
			sent_count, result_count);
		if (fail_count == 0)
			$display("tb_hammersley_cap_direction_generator_unit: done, clean");
		else
			$display("tb_hammersley_cap_direction_generator_unit: done, errors");
		$finish;
	end

endmodule
